// ===== src/rcp_pkg.sv =====
// Package for the rope chain block: word and vector types, mode and register
// codes, shared saturating arithmetic. No dependencies.
`default_nettype none
package rcp_pkg;

    localparam int RCP_MAX_LINKS = 32;
    localparam int WORD_W        = 32;

    typedef logic [WORD_W-1:0]           word_t;
    typedef logic [2:0][WORD_W-1:0]      vec3_t;

    // Item modes.
    localparam logic [2:0] M_TICK      = 3'd0;
    localparam logic [2:0] M_DRAG_HEAD = 3'd1;
    localparam logic [2:0] M_DRAG_TAIL = 3'd2;
    localparam logic [2:0] M_STRETCH   = 3'd3;
    localparam logic [2:0] M_IMP_ALL   = 3'd4;
    localparam logic [2:0] M_IMP_ONE   = 3'd5;
    localparam logic [2:0] M_SET_SPD   = 3'd6;
    localparam logic [2:0] M_READ      = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] R_LINK_COUNT    = 3'd0;
    localparam logic [2:0] R_LINK_DISTANCE = 3'd1;
    localparam logic [2:0] R_FORCE_X       = 3'd2;
    localparam logic [2:0] R_FORCE_Y       = 3'd3;
    localparam logic [2:0] R_FORCE_Z       = 3'd4;

    localparam logic [5:0]  LINK_COUNT_RST    = 6'd8;
    localparam logic [30:0] LINK_DISTANCE_RST = 31'd65536;

    localparam word_t SAT_MAX = 32'h7FFF_FFFF;
    localparam word_t SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic start;
        logic direct;
    } dir_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic far;
    } dir_stat_t;

    function automatic word_t sat_add(word_t a, word_t b, logic sub);
        logic [WORD_W:0] s;
        if (sub)
            s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        else
            s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? SAT_MIN : SAT_MAX;
        return s[WORD_W-1:0];
    endfunction

    function automatic vec3_t sat_vadd(vec3_t a, vec3_t b, logic sub);
        vec3_t r;
        for (int k = 0; k < 3; k++)
            r[k] = sat_add(a[k], b[k], sub);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/rcp_ifs.sv =====
// Channel interfaces of the rope chain block: item request, result and
// configuration write. No dependencies.
`default_nettype none
interface rcp_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_z;
    logic [4:0]         link_index;
    modport source (output valid, mode, arg_x, arg_y, arg_z, link_index, input ready);
    modport sink   (input valid, mode, arg_x, arg_y, arg_z, link_index, output ready);
endinterface

interface rcp_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] spd_x;
    logic signed [31:0] spd_y;
    logic signed [31:0] spd_z;
    logic               link_valid;
    modport source (output valid, pos_x, pos_y, pos_z, spd_x, spd_y, spd_z, link_valid,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, spd_x, spd_y, spd_z, link_valid,
                    output ready);
endinterface

interface rcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [31:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== src/rcp_dir.sv =====
// Direction unit: distance test and scaling of a difference to link_distance,
// with a shared multiplier, a bit-pair square root and a radix-2 divider.
// Depends on rcp_pkg.
`default_nettype none
module rcp_dir (
    input  logic             clk,
    input  logic             rst_n,
    input  rcp_pkg::dir_req_t req,
    input  rcp_pkg::vec3_t   a,
    input  rcp_pkg::vec3_t   b,
    input  logic [30:0]      link_distance,
    output rcp_pkg::dir_stat_t stat,
    output rcp_pkg::vec3_t   dir
);
    import rcp_pkg::*;

    localparam logic [3:0] D_IDLE = 4'd0;
    localparam logic [3:0] D_SQ   = 4'd1;
    localparam logic [3:0] D_LD2  = 4'd2;
    localparam logic [3:0] D_CMP  = 4'd3;
    localparam logic [3:0] D_SQRT = 4'd4;
    localparam logic [3:0] D_MUL  = 4'd5;
    localparam logic [3:0] D_CHK  = 4'd6;
    localparam logic [3:0] D_DIV  = 4'd7;

    logic [3:0]  state_reg;
    logic        done_reg;
    logic        far_reg;
    logic        direct_reg;
    logic        big_reg;
    logic [31:0] mag_reg [3];
    logic [2:0]  neg_reg;
    logic [30:0] ld_reg;
    logic [63:0] mul_reg;
    logic [63:0] sum_reg;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [31:0] len_reg;
    logic [31:0] rem_reg;
    logic [30:0] q_reg;
    logic [1:0]  k_reg;
    logic [4:0]  cnt_reg;
    vec3_t       dir_reg;
    logic        div_last_reg;
    logic [1:0]  div_k_reg;

    // Differences at start; a magnitude above 2^31 halves all components.
    logic [32:0] d_in  [3];
    logic [32:0] m_in  [3];
    logic        big_in;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] r_plus;
    logic [32:0] rem_sh;
    logic [31:0] q_full;
    word_t       comp;
    vec3_t       dir_out;

    always_comb
    begin
        big_in = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            d_in[k] = {a[k][31], a[k]} - {b[k][31], b[k]};
            m_in[k] = d_in[k][32] ? 33'(-d_in[k]) : d_in[k];
            if (m_in[k] > 33'h0_8000_0000)
                big_in = 1'b1;
        end
    end

    always_comb
    begin
        mul_a = mag_reg[k_reg];
        mul_b = {1'b0, ld_reg};
        if (state_reg == D_SQ)
        begin
            mul_a = mag_reg[cnt_reg[1:0]];
            mul_b = mag_reg[cnt_reg[1:0]];
        end
        else if (state_reg == D_LD2)
            mul_a = {1'b0, ld_reg};
    end

    assign r_plus = r_reg + bit_reg;
    assign rem_sh = {rem_reg, mul_reg[30]};
    assign q_full = {1'b0, q_reg};
    assign comp   = neg_reg[div_k_reg] ? word_t'(-q_full) : q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            far_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                        state_reg <= D_SQ;
                end
                D_SQ:
                begin
                    if (cnt_reg == 5'd3)
                        state_reg <= D_LD2;
                end
                D_LD2:
                    state_reg <= D_CMP;
                D_CMP:
                begin
                    if (!direct_reg && !big_reg && sum_reg <= mul_reg)
                    begin
                        done_reg  <= 1'b1;
                        far_reg   <= 1'b0;
                        state_reg <= D_IDLE;
                    end
                    else
                        state_reg <= D_SQRT;
                end
                D_SQRT:
                begin
                    if (cnt_reg == 5'd31)
                        state_reg <= D_MUL;
                end
                D_MUL:
                begin
                    if (len_reg == 32'd0)
                    begin
                        done_reg  <= 1'b1;
                        far_reg   <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                        state_reg <= D_CHK;
                end
                D_CHK:
                begin
                    if (mul_reg[62:0] >= {len_reg, 31'd0})
                    begin
                        if (k_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            far_reg   <= 1'b1;
                            state_reg <= D_IDLE;
                        end
                        else
                            state_reg <= D_MUL;
                    end
                    else
                        state_reg <= D_DIV;
                end
                D_DIV:
                begin
                    if (cnt_reg == 5'd30)
                    begin
                        if (k_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            far_reg   <= 1'b1;
                            state_reg <= D_IDLE;
                        end
                        else
                            state_reg <= D_MUL;
                    end
                end
                default:
                    state_reg <= D_IDLE;
            endcase
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mag_reg[k] <= big_in ? m_in[k][32:1] : m_in[k][31:0];
                        neg_reg[k] <= d_in[k][32];
                    end
                    big_reg    <= big_in;
                    direct_reg <= req.direct;
                    ld_reg     <= link_distance;
                    sum_reg    <= 64'd0;
                    cnt_reg    <= 5'd0;
                end
            end
            D_SQ:
            begin
                if (cnt_reg != 5'd0)
                    sum_reg <= sum_reg + mul_reg;
                if (cnt_reg != 5'd3)
                    mul_reg <= mul_a * mul_b;
                cnt_reg <= cnt_reg + 5'd1;
            end
            D_LD2:
                mul_reg <= mul_a * mul_b;
            D_CMP:
            begin
                x_reg   <= sum_reg;
                r_reg   <= 64'd0;
                bit_reg <= 64'h4000_0000_0000_0000;
                cnt_reg <= 5'd0;
            end
            D_SQRT:
            begin
                if (x_reg >= r_plus)
                begin
                    x_reg <= x_reg - r_plus;
                    r_reg <= (r_reg >> 1) + bit_reg;
                    if (cnt_reg == 5'd31)
                        len_reg <= 32'((r_reg >> 1) + bit_reg);
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                    if (cnt_reg == 5'd31)
                        len_reg <= 32'(r_reg >> 1);
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                k_reg   <= 2'd0;
            end
            D_MUL:
            begin
                if (len_reg == 32'd0)
                    dir_reg <= '0;
                mul_reg <= mul_a * mul_b;
            end
            D_CHK:
            begin
                if (mul_reg[62:0] >= {len_reg, 31'd0})
                begin
                    dir_reg[k_reg] <= neg_reg[k_reg] ? word_t'(-SAT_MAX) : SAT_MAX;
                    k_reg          <= k_reg + 2'd1;
                end
                else
                begin
                    rem_reg <= mul_reg[62:31];
                    q_reg   <= 31'd0;
                    cnt_reg <= 5'd0;
                end
            end
            D_DIV:
            begin
                // One quotient bit per cycle, next dividend bit from the product.
                if (rem_sh >= {1'b0, len_reg})
                begin
                    rem_reg <= 32'(rem_sh - {1'b0, len_reg});
                    q_reg   <= {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    q_reg   <= {q_reg[29:0], 1'b0};
                end
                mul_reg <= mul_reg << 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
        if (div_last_reg)
            dir_reg[div_k_reg] <= comp;
    end

    // The last quotient bit is registered in q_reg as D_DIV ends; div_last_reg flags it for storing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_last_reg <= 1'b0;
        else
            div_last_reg <= (state_reg == D_DIV) && (cnt_reg == 5'd30);
    end

    always_ff @(posedge clk)
    begin
        div_k_reg <= k_reg;
    end

    always_comb
    begin
        dir_out = dir_reg;
        if (div_last_reg)
            dir_out[div_k_reg] = comp;
    end

    assign dir       = dir_out;
    assign stat.busy = (state_reg != D_IDLE) || div_last_reg;
    assign stat.done = done_reg && !div_last_reg ? 1'b1 : (div_last_reg && div_k_reg == 2'd2);
    assign stat.far  = div_last_reg ? 1'b1 : far_reg;

endmodule
`default_nettype wire

// ===== src/rope_chain_physics.sv =====
// Rope chain: link positions and speeds in two synchronous memories, walked
// link by link. Tick, drag and stretch use the direction unit, with its shared
// square root and its 31-step divider per component. One item is in flight
// at a time. Reset restores the configuration defaults and marks every link
// entry unwritten, so all links read as zero.
`default_nettype none
module rope_chain_physics #(
    parameter int MAX_LINKS = rcp_pkg::RCP_MAX_LINKS
) (
    input  logic      clk,
    input  logic      rst_n,
    rcp_req_if.sink   req,
    rcp_rsp_if.source rsp,
    rcp_cfg_if.sink   cfg
);
    import rcp_pkg::*;

    localparam int AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int NW = $clog2(MAX_LINKS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_DAT  = 3'd2;
    localparam logic [2:0] ST_DIR  = 3'd3;
    localparam logic [2:0] ST_STR  = 3'd4;
    localparam logic [2:0] ST_RPT  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Configuration.
    logic [5:0]  link_count_reg;
    logic [30:0] link_distance_reg;
    vec3_t       force_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_count_reg    <= LINK_COUNT_RST;
            link_distance_reg <= LINK_DISTANCE_RST;
            force_reg         <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.addr)
                R_LINK_COUNT:    link_count_reg    <= cfg.data[5:0];
                R_LINK_DISTANCE: link_distance_reg <= cfg.data[30:0];
                R_FORCE_X:       force_reg[0]      <= cfg.data;
                R_FORCE_Y:       force_reg[1]      <= cfg.data;
                R_FORCE_Z:       force_reg[2]      <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end
    assign cfg.ready = 1'b1;

    // Link memories with one write and one registered read port each.
    vec3_t pos_mem [MAX_LINKS];
    vec3_t spd_mem [MAX_LINKS];
    logic [MAX_LINKS-1:0] pos_vld_reg;
    logic [MAX_LINKS-1:0] spd_vld_reg;
    vec3_t pos_q, spd_q;
    logic  pos_vq, spd_vq;
    vec3_t pos_rd, spd_rd;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          pos_we, spd_we;
    logic [AW-1:0] pos_wa, spd_wa;
    vec3_t         pos_wd, spd_wd;

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        if (spd_we)
            spd_mem[spd_wa] <= spd_wd;
        if (rd_en)
        begin
            pos_q <= pos_mem[rd_addr];
            spd_q <= spd_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_vld_reg <= '0;
            spd_vld_reg <= '0;
            pos_vq      <= 1'b0;
            spd_vq      <= 1'b0;
        end
        else
        begin
            if (pos_we)
                pos_vld_reg[pos_wa] <= 1'b1;
            if (spd_we)
                spd_vld_reg[spd_wa] <= 1'b1;
            if (rd_en)
            begin
                pos_vq <= pos_vld_reg[rd_addr];
                spd_vq <= spd_vld_reg[rd_addr];
            end
        end
    end

    assign pos_rd = pos_vq ? pos_q : '0;
    assign spd_rd = spd_vq ? spd_q : '0;

    // Item state.
    logic [2:0]    state_reg, state_next;
    logic [2:0]    mode_reg, mode_next;
    vec3_t         arg_reg, arg_next;
    logic [4:0]    idx_reg, idx_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] i_reg, i_next;
    vec3_t         p_reg, p_next;
    vec3_t         want_reg, want_next;
    logic          rep_valid_reg, rep_valid_next;

    logic          out_valid_reg;
    vec3_t         out_pos_reg, out_spd_reg;
    logic          out_link_valid_reg;

    dir_req_t      dir_req;
    dir_stat_t     dir_stat;
    vec3_t         dir_a, dir_b, dir_v;

    rcp_dir u_dir (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (dir_req),
        .a             (dir_a),
        .b             (dir_b),
        .link_distance (link_distance_reg),
        .stat          (dir_stat),
        .dir           (dir_v)
    );

    logic [NW+5:0]   cnt_ext, lim_ext;
    logic [NW-1:0]   n_cfg;
    logic [NW+4:0]   in_idx_ext, reg_idx_ext;
    logic            in_idx_ok, reg_idx_ok;
    logic [NW-1:0]   walk_i;
    logic [NW-1:0]   tail_i;
    logic [NW-1:0]   i_inc;
    vec3_t           arg_in, s_new, sum_tmp;
    logic            accept;
    logic            out_free;

    assign cnt_ext     = {{NW{1'b0}}, link_count_reg};
    assign lim_ext     = (NW+6)'(MAX_LINKS);
    assign n_cfg       = (cnt_ext > lim_ext) ? lim_ext[NW-1:0] : cnt_ext[NW-1:0];
    assign in_idx_ext  = {{NW{1'b0}}, req.link_index};
    assign reg_idx_ext = {{NW{1'b0}}, idx_reg};
    assign in_idx_ok   = in_idx_ext < {5'd0, n_cfg};
    assign reg_idx_ok  = reg_idx_ext < {5'd0, n_reg};
    assign tail_i      = n_reg - NW'(1);
    assign walk_i      = (mode_reg == M_DRAG_TAIL) ? NW'(tail_i - i_reg) : i_reg;
    assign i_inc       = i_reg + NW'(1);
    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign req.ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        arg_in[0] = req.arg_x;
        arg_in[1] = req.arg_y;
        arg_in[2] = req.arg_z;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        arg_next       = arg_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        want_next      = want_reg;
        rep_valid_next = rep_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = walk_i[AW-1:0];
        pos_we         = 1'b0;
        pos_wa         = walk_i[AW-1:0];
        pos_wd         = p_reg;
        spd_we         = 1'b0;
        spd_wa         = walk_i[AW-1:0];
        spd_wd         = spd_rd;
        dir_req        = '0;
        dir_a          = p_reg;
        dir_b          = pos_rd;
        s_new          = sat_vadd(spd_rd, force_reg, 1'b0);
        sum_tmp        = sat_vadd(pos_rd, s_new, 1'b0);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    arg_next  = arg_in;
                    idx_next  = req.link_index;
                    n_next    = n_cfg;
                    i_next    = '0;
                    p_next    = arg_in;
                    if (n_cfg == '0)
                        state_next = ST_RPT;
                    else
                    begin
                        case (req.mode)
                            M_TICK, M_IMP_ALL:
                                state_next = ST_RD;
                            M_DRAG_HEAD, M_DRAG_TAIL:
                            begin
                                pos_we     = 1'b1;
                                pos_wa     = (req.mode == M_DRAG_TAIL)
                                             ? AW'(n_cfg - NW'(1)) : '0;
                                pos_wd     = arg_in;
                                i_next     = NW'(1);
                                state_next = (n_cfg > NW'(1)) ? ST_RD : ST_RPT;
                            end
                            M_STRETCH:
                            begin
                                if (n_cfg >= NW'(2))
                                begin
                                    dir_req.start  = 1'b1;
                                    dir_req.direct = 1'b1;
                                    dir_a          = arg_in;
                                    dir_b          = '0;
                                    state_next     = ST_DIR;
                                end
                                else
                                    state_next = ST_RPT;
                            end
                            M_IMP_ONE:
                            begin
                                i_next     = in_idx_ext[NW-1:0];
                                state_next = in_idx_ok ? ST_RD : ST_RPT;
                            end
                            M_SET_SPD:
                            begin
                                spd_we     = in_idx_ok;
                                spd_wa     = in_idx_ext[AW-1:0];
                                spd_wd     = arg_in;
                                state_next = ST_RPT;
                            end
                            default:
                                state_next = ST_RPT;
                        endcase
                    end
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_DAT;
            end
            ST_DAT:
            begin
                case (mode_reg)
                    M_TICK:
                    begin
                        spd_we = 1'b1;
                        spd_wd = s_new;
                        if (i_reg == '0)
                        begin
                            p_next = sum_tmp;
                            pos_we = 1'b1;
                            pos_wd = sum_tmp;
                            i_next = i_inc;
                            state_next = (i_inc < n_reg) ? ST_RD : ST_RPT;
                        end
                        else
                        begin
                            want_next     = sum_tmp;
                            dir_req.start = 1'b1;
                            dir_a         = sum_tmp;
                            dir_b         = p_reg;
                            state_next    = ST_DIR;
                        end
                    end
                    M_DRAG_HEAD, M_DRAG_TAIL:
                    begin
                        dir_req.start = 1'b1;
                        state_next    = ST_DIR;
                    end
                    M_STRETCH:
                    begin
                        p_next     = pos_rd;
                        i_next     = NW'(1);
                        state_next = ST_STR;
                    end
                    M_IMP_ALL:
                    begin
                        spd_we     = 1'b1;
                        spd_wd     = sat_vadd(spd_rd, arg_reg, 1'b0);
                        i_next     = i_inc;
                        state_next = (i_inc < n_reg) ? ST_RD : ST_RPT;
                    end
                    M_IMP_ONE:
                    begin
                        spd_we     = 1'b1;
                        spd_wd     = sat_vadd(spd_rd, arg_reg, 1'b0);
                        state_next = ST_RPT;
                    end
                    default:
                        state_next = ST_RPT;
                endcase
            end
            ST_DIR:
            begin
                if (dir_stat.done)
                begin
                    case (mode_reg)
                        M_TICK:
                        begin
                            p_next     = dir_stat.far ? sat_vadd(p_reg, dir_v, 1'b0)
                                                      : want_reg;
                            pos_we     = 1'b1;
                            pos_wd     = p_next;
                            i_next     = i_inc;
                            state_next = (i_inc < n_reg) ? ST_RD : ST_RPT;
                        end
                        M_DRAG_HEAD, M_DRAG_TAIL:
                        begin
                            if (!dir_stat.far)
                                state_next = ST_RPT;
                            else
                            begin
                                p_next     = sat_vadd(p_reg, dir_v, 1'b1);
                                pos_we     = 1'b1;
                                pos_wd     = p_next;
                                i_next     = i_inc;
                                state_next = (i_inc < n_reg) ? ST_RD : ST_RPT;
                            end
                        end
                        default:
                        begin
                            i_next     = '0;
                            state_next = ST_RD;
                        end
                    endcase
                end
            end
            ST_STR:
            begin
                // Each later link sits one scaled step beyond the one before it.
                p_next     = sat_vadd(p_reg, dir_v, 1'b0);
                pos_we     = 1'b1;
                pos_wd     = p_next;
                i_next     = i_inc;
                state_next = (i_inc < n_reg) ? ST_STR : ST_RPT;
            end
            ST_RPT:
            begin
                if (mode_reg inside {M_IMP_ONE, M_SET_SPD, M_READ})
                begin
                    rep_valid_next = reg_idx_ok;
                    rd_addr        = reg_idx_ext[AW-1:0];
                end
                else
                begin
                    rep_valid_next = (n_reg != '0);
                    rd_addr        = tail_i[AW-1:0];
                end
                rd_en      = rep_valid_next;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= M_READ;
            idx_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            rep_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            rep_valid_reg <= rep_valid_next;
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        arg_reg  <= arg_next;
        p_reg    <= p_next;
        want_reg <= want_next;
        if (state_reg == ST_OUT && out_free)
        begin
            out_pos_reg        <= rep_valid_reg ? pos_rd : '0;
            out_spd_reg        <= rep_valid_reg ? spd_rd : '0;
            out_link_valid_reg <= rep_valid_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.pos_x      = out_pos_reg[0];
    assign rsp.pos_y      = out_pos_reg[1];
    assign rsp.pos_z      = out_pos_reg[2];
    assign rsp.spd_x      = out_spd_reg[0];
    assign rsp.spd_y      = out_spd_reg[1];
    assign rsp.spd_z      = out_spd_reg[2];
    assign rsp.link_valid = out_link_valid_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("item accepted while another is in flight");

    a_dir_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dir_req.start |-> !dir_stat.busy)
        else $error("direction unit started while busy");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAT) |-> (i_reg < n_reg))
        else $error("link walk beyond the active chain");

    a_no_write_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RPT || state_reg == ST_OUT) |-> (!pos_we && !spd_we))
        else $error("link memory written after the walk ended");

endmodule
`default_nettype wire
